// File: design/ffc_pkg.sv
package ffc_pkg;

    // Default queue depth
    localparam int unsigned DEPTH_DEFAULT = 128;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OCC_W   = 8;

    // Operation codes
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_GET    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic                      cmp_en;
        logic                      apply;
        logic                      op_push;
        logic                      op_cancel;
        logic signed [VALUE_W-1:0] data;
    } cell_ctrl_t;

endpackage

// File: design/fifo_with_cancel_by_value.sv
// Queue of 32-bit identifiers with push, get-oldest and cancel-by-value.
// Input channel: in_valid/in_ready carry a request (op, value). Output
// channel: out_valid/out_ready carry one result per request (out_value,
// status, occupancy).
// Storage is a row of DEPTH cells kept compacted oldest-first. Every cell
// compares its entry against the request value in parallel; the oldest
// match is removed and younger cells shift down one place together.
// A request passes a compare step and then an update step, set by the
// sequencer walking compare, update and idle; a new request is accepted
// only in idle, so one request is in flight at a time.
// The result sits in an output register, so the next request is taken
// while the result waits. If the receiver stalls with a result pending,
// the update of the following request waits until the register frees.
// Reset clears all cell valid flags and the count: the queue is empty and
// no result is pending. No clearing pass is needed.
module fifo_with_cancel_by_value #(
    parameter int unsigned DEPTH = ffc_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           op,
    input  logic signed [ffc_pkg::VALUE_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ffc_pkg::VALUE_W-1:0]   out_value,
    output logic [1:0]                           status,
    output logic [ffc_pkg::OCC_W-1:0]            occupancy
);
    import ffc_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    state_t                    state_reg, state_next;
    logic [1:0]                op_reg;
    logic signed [VALUE_W-1:0] data_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [1:0]                status_reg, status_next;
    logic [OCC_W-1:0]          occ_reg, occ_next;
    logic                      out_free;
    logic                      in_fire;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] chain_value [DEPTH+1];
    logic                      chain_valid [DEPTH+1];
    logic                      kill        [DEPTH+1];

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;

    // Request latch
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= op;
            data_reg <= value;
        end
    end

    // Cell control
    always_comb
    begin
        ctrl.cmp_en    = (state_reg == S_CMP);
        ctrl.apply     = (state_reg == S_APPLY) & out_free;
        ctrl.op_push   = (op_reg == OP_PUSH);
        ctrl.op_cancel = (op_reg == OP_CANCEL);
        ctrl.data      = data_reg;
    end

    // Chain ends: cell 0 sees a valid left side, last cell an empty right
    assign kill[0]            = (op_reg == OP_GET);
    assign chain_valid[DEPTH] = 1'b0;
    assign chain_value[DEPTH] = '0;

    logic left_v [DEPTH];
    assign left_v[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g > 0)
            begin : g_left
                assign left_v[g] = chain_valid[g-1];
            end
            ffc_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .right_value (chain_value[g+1]),
                .right_valid (chain_valid[g+1]),
                .left_valid  (left_v[g]),
                .kill_in     (kill[g]),
                .kill_out    (kill[g+1]),
                .cell_value  (chain_value[g]),
                .cell_valid  (chain_valid[g])
            );
        end
    endgenerate

    // Sequencer and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    status_next    = ST_OK;
                    case (op_reg)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_value_next = chain_value[0];
                                count_next     = count_reg - 1'b1;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (kill[DEPTH])
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    occ_next = OCC_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        occ_reg       <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule

// File: design/ffc_cell.sv
module ffc_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ffc_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [ffc_pkg::VALUE_W-1:0]    right_value,
    input  logic                                  right_valid,
    input  logic                                  left_valid,
    input  logic                                  kill_in,
    output logic                                  kill_out,
    output logic signed [ffc_pkg::VALUE_W-1:0]    cell_value,
    output logic                                  cell_valid
);
    import ffc_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic                      valid_reg;
    logic                      match_reg;
    logic                      hit;
    logic                      shift;
    logic                      load;

    // Removal ripples: a cell shifts when it or an older cell was removed
    assign hit      = ctrl.op_cancel & match_reg;
    assign kill_out = kill_in | hit;
    assign shift    = ctrl.apply & kill_out;
    // Push lands in the first empty cell
    assign load     = ctrl.apply & ctrl.op_push & left_valid & ~valid_reg;

    // Valid and match flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp_en)
            begin
                match_reg <= valid_reg & (value_reg == ctrl.data);
            end
            if (shift)
            begin
                valid_reg <= right_valid;
            end
            else if (load)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // Stored identifier
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= right_value;
        end
        else if (load)
        begin
            value_reg <= ctrl.data;
        end
    end

    assign cell_value = value_reg;
    assign cell_valid = valid_reg;

endmodule

// File: design/ffc_checker.sv
module ffc_checker #(
    parameter int unsigned DEPTH = ffc_pkg::DEPTH_DEFAULT
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [ffc_pkg::VALUE_W-1:0]   out_value,
    input logic [1:0]                           status,
    input logic [ffc_pkg::OCC_W-1:0]            occupancy
);
    import ffc_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(status))
        else $error("result changed while stalled");

    // One request in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // Empty status only on an empty queue
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> occupancy == '0)
        else $error("empty status with entries held");

    // Full status only at capacity
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == OCC_W'(DEPTH))
        else $error("full status below capacity");

    // Only a successful get returns a value
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_value != '0 |-> status == ST_OK)
        else $error("value returned with error status");

endmodule

bind fifo_with_cancel_by_value ffc_checker #(.DEPTH(DEPTH)) u_ffc_checker (.*);
